/* sv/sha_pkg.sv */
// ----------------------------------------------------------------------------
// sha_pkg
// shared types, constants and the rotate function of the sha-256 hash engine
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef enum logic [2:0] {
        ST_ACCEPT,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_OUTPUT
    } t_state;

    // word source for the block buffer
    typedef enum logic [1:0] {
        SRC_INPUT,
        SRC_ZERO,
        SRC_LEN_HI,
        SRC_LEN_LO
    } t_src;

    // controller to datapath commands
    typedef struct packed {
        logic        push;       // write a word into the buffer
        t_src        src;
        logic        count_in;   // add input bits to the length
        logic        load;       // copy buffer and chain into round registers
        logic        round;      // run one round
        logic [5:0]  rnd;        // round index
        logic        update;     // add working vars to chain
        logic        reinit;     // restore initial hash, clear length
        logic        shift_out;  // rotate chain for digest output
    } t_cmd;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] HINIT [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] KROUND [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

/* sv/sha_ctrl.sv */
// ----------------------------------------------------------------------------
// sha_ctrl
// sequencer: word intake, 64-round loop, padding and digest output
// ----------------------------------------------------------------------------
module sha_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_s_last,
    input  logic [2:0]    i_s_nbytes,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    output logic          o_m_last,
    input  logic          i_m_tready,
    output sha_pkg::t_cmd o_cmd,
    output logic [3:0]    o_fill
);
    import sha_pkg::*;

    t_state     r_state, n_state;
    logic [3:0] r_fill, n_fill;
    logic [5:0] r_rnd, n_rnd;
    logic [2:0] r_oidx, n_oidx;
    logic       r_final, n_final;   // message ended, padding active
    logic       r_extra, n_extra;   // 0x80 word still due (full final word)
    logic       r_len_done, n_len_done;
    logic       r_len_wait, n_len_wait;
    logic       s_beat, m_beat;

    assign s_beat = i_s_tvalid && o_s_tready;
    assign m_beat = o_m_tvalid && i_m_tready;
    assign o_fill = r_fill;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCEPT;
            r_fill  <= '0;
            r_rnd   <= '0;
            r_oidx  <= '0;
            r_final <= 1'b0;
            r_extra <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_rnd   <= n_rnd;
            r_oidx  <= n_oidx;
            r_final <= n_final;
            r_extra <= n_extra;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_rnd   = r_rnd;
        n_oidx  = r_oidx;
        n_final = r_final;
        n_extra = r_extra;
        case (r_state)
            ST_ACCEPT: begin
                if (s_beat) begin
                    n_fill = r_fill + 4'd1;
                    if (i_s_last) begin
                        n_final = 1'b1;
                        n_extra = (i_s_nbytes >= 3'd4);
                    end
                    if (r_fill == 4'd15) n_state = ST_LOAD;
                    else if (i_s_last) n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                n_fill = r_fill + 4'd1;
                n_extra = 1'b0;
                if (r_fill == 4'd15) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_rnd   = '0;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == 6'd63) n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                // final block: length was written into slots 14 and 15
                if (r_final && !r_extra && r_len_done) begin
                    n_state = ST_OUTPUT;
                    n_oidx  = '0;
                end else if (r_final) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_ACCEPT;
                end
            end
            ST_OUTPUT: begin
                if (m_beat) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        n_state = ST_ACCEPT;
                        n_final = 1'b0;
                    end
                end
            end
            default: n_state = ST_ACCEPT;
        endcase
    end

    // length slots land in 14 and 15 only once padding is done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_len_done <= 1'b0;
        else          r_len_done <= n_len_done;
    end
    always_comb begin
        n_len_done = r_len_done;
        if (r_state == ST_PAD && r_fill == 4'd15 && !r_extra && !r_len_wait)
            n_len_done = 1'b1;
        if (r_state == ST_ACCEPT && s_beat && i_s_last && r_fill == 4'd15
            && i_s_nbytes < 3'd4) n_len_done = 1'b0;
        if (r_state == ST_OUTPUT) n_len_done = 1'b0;
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_cmd.src   = SRC_INPUT;
        o_cmd.rnd   = r_rnd;
        o_s_tready  = 1'b0;
        o_m_tvalid  = 1'b0;
        o_m_last    = 1'b0;
        case (r_state)
            ST_ACCEPT: begin
                o_s_tready     = 1'b1;
                o_cmd.push     = s_beat;
                o_cmd.count_in = s_beat;
            end
            ST_PAD: begin
                o_cmd.push = 1'b1;
                if (r_extra)                             o_cmd.src = SRC_INPUT;
                else if (r_fill == 4'd14 && !r_len_wait) o_cmd.src = SRC_LEN_HI;
                else if (r_fill == 4'd15 && !r_len_wait) o_cmd.src = SRC_LEN_LO;
                else                                     o_cmd.src = SRC_ZERO;
            end
            ST_LOAD:   o_cmd.load   = 1'b1;
            ST_ROUND:  o_cmd.round  = 1'b1;
            ST_UPDATE: o_cmd.update = 1'b1;
            ST_OUTPUT: begin
                o_m_tvalid      = 1'b1;
                o_m_last        = (r_oidx == 3'd7);
                o_cmd.shift_out = m_beat;
                o_cmd.reinit    = m_beat && (r_oidx == 3'd7);
            end
            default: ;
        endcase
    end

    // length must wait for a fresh block when the pad word passed slot 13
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_len_wait <= 1'b0;
        else          r_len_wait <= n_len_wait;
    end
    always_comb begin
        n_len_wait = r_len_wait;
        if (r_state == ST_ACCEPT && s_beat && i_s_last)
            n_len_wait = (i_s_nbytes >= 3'd4) ? (r_fill >= 4'd13) : (r_fill >= 4'd14);
        if (r_state == ST_LOAD) n_len_wait = 1'b0;
    end

endmodule

/* sv/sha_dp.sv */
// ----------------------------------------------------------------------------
// sha_dp
// datapath: block buffer, rolling schedule, round unit and chain value
// ----------------------------------------------------------------------------
module sha_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sha_pkg::t_cmd i_cmd,
    input  logic [31:0]   i_data,
    input  logic [2:0]    i_nbytes,
    input  logic          i_last,
    input  logic [3:0]    i_fill,
    output logic [31:0]   o_digest
);
    import sha_pkg::*;

    logic [31:0] r_buf [16];
    logic [31:0] r_w   [16];
    logic [31:0] r_v   [8];
    logic [31:0] r_h   [8];
    logic [63:0] r_bits;
    logic [31:0] r_pend;          // 0x80 word held back for the next slot
    logic [31:0] s_in_word, s_push_word, s_mask, s_wnew, s_sched;
    logic [31:0] s_t1, s_t2, s_e, s_a;
    logic [2:0]  s_nb;
    logic [6:0]  s_addbits;

    // final-word masking and pad byte
    always_comb begin
        s_nb = (i_nbytes > 3'd4) ? 3'd4 : i_nbytes;
        if (!i_last) s_nb = 3'd4;
        case (s_nb)
            3'd0:    s_mask = 32'h0000_0000;
            3'd1:    s_mask = 32'hFF00_0000;
            3'd2:    s_mask = 32'hFFFF_0000;
            3'd3:    s_mask = 32'hFFFF_FF00;
            default: s_mask = 32'hFFFF_FFFF;
        endcase
        s_in_word = i_data & s_mask;
        if (i_last && s_nb != 3'd4)
            s_in_word = s_in_word | ({24'd0, PAD_BYTE} << (5'd24 - {s_nb[1:0], 3'd0}));
        s_addbits = {1'b0, s_nb, 3'd0};
    end

    always_comb begin
        case (i_cmd.src)
            SRC_INPUT:  s_push_word = i_cmd.count_in ? s_in_word : r_pend;
            SRC_LEN_HI: s_push_word = r_bits[63:32];
            SRC_LEN_LO: s_push_word = r_bits[31:0];
            default:    s_push_word = '0;
        endcase
    end

    // buffer writes and bit length
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) r_buf[i_fill] <= s_push_word;
        if (i_cmd.count_in) r_pend <= {PAD_BYTE, 24'd0};
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reinit) r_bits <= '0;
        else if (i_cmd.count_in)      r_bits <= r_bits + {57'd0, s_addbits};
    end

    // schedule: window slot rnd[3:0] is updated in place from round 16 on
    always_comb begin
        s_sched = (rotr(r_w[i_cmd.rnd[3:0] - 4'd2], 17)
                   ^ rotr(r_w[i_cmd.rnd[3:0] - 4'd2], 19)
                   ^ (r_w[i_cmd.rnd[3:0] - 4'd2] >> 10))
                + r_w[i_cmd.rnd[3:0] - 4'd7]
                + (rotr(r_w[i_cmd.rnd[3:0] - 4'd15], 7)
                   ^ rotr(r_w[i_cmd.rnd[3:0] - 4'd15], 18)
                   ^ (r_w[i_cmd.rnd[3:0] - 4'd15] >> 3))
                + r_w[i_cmd.rnd[3:0]];
        s_wnew = (i_cmd.rnd >= 6'd16) ? s_sched : r_w[i_cmd.rnd[3:0]];
        s_e = r_v[4];
        s_a = r_v[0];
        s_t1 = r_v[7] + (rotr(s_e, 6) ^ rotr(s_e, 11) ^ rotr(s_e, 25))
             + ((s_e & r_v[5]) ^ (~s_e & r_v[6])) + KROUND[i_cmd.rnd] + s_wnew;
        s_t2 = (rotr(s_a, 2) ^ rotr(s_a, 13) ^ rotr(s_a, 22))
             + ((s_a & r_v[1]) ^ (s_a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // round registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_w <= r_buf;
            r_v <= r_h;
        end else if (i_cmd.round) begin
            r_w[i_cmd.rnd[3:0]] <= s_wnew;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + s_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= s_t1 + s_t2;
        end
    end

    // chain value: update, rotate out, reinit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reinit) begin
            r_h <= HINIT;
        end else if (i_cmd.update) begin
            for (int k = 0; k < 8; k++) r_h[k] <= r_h[k] + r_v[k];
        end else if (i_cmd.shift_out) begin
            for (int k = 0; k < 7; k++) r_h[k] <= r_h[k+1];
            r_h[7] <= r_h[0];
        end
    end

    assign o_digest = r_h[0];

endmodule

/* sv/sha256_hash_engine.sv */
// ----------------------------------------------------------------------------
// sha256_hash_engine
// sha-256 digest of a byte message streamed as big-endian 32-bit words
// ----------------------------------------------------------------------------
// usage
//   input beats: tdata = data_word, tuser = valid_bytes, tlast = end_of_message.
//   a word without tlast adds four bytes; the tlast word carries 0 to 4 bytes,
//   left-aligned (counts above four count as four).
//   every sixteenth word starts a compression: a load, 64 rounds
//   (one round per cycle in the shared round unit) and a chain update,
//   during which tready is low.
//   after tlast the engine writes padding one word per cycle and runs one or
//   two more compressions, two when the length needs an extra block.
//   the eight digest words follow, most significant first, tlast on the eighth.
//   a stalled output simply holds the current digest word; no new input is
//   taken until all eight beats have gone out, then the initial hash values
//   and a zero length are restored.
//   reset (synchronous, active low) loads the initial hash values, clears the
//   length and returns to word intake; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sha256_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] data_word
    input  logic [2:0]  s_axis_tuser,   // [2:0] valid_bytes
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic        m_axis_tlast
);
    import sha_pkg::*;

    t_cmd       s_cmd;
    logic [3:0] s_fill;

    sha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_last   (s_axis_tlast),
        .i_s_nbytes (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_last   (m_axis_tlast),
        .i_m_tready (m_axis_tready),
        .o_cmd      (s_cmd),
        .o_fill     (s_fill)
    );

    sha_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (s_cmd),
        .i_data   (s_axis_tdata),
        .i_nbytes (s_axis_tuser),
        .i_last   (s_axis_tlast),
        .i_fill   (s_fill),
        .o_digest (m_axis_tdata)
    );

endmodule

/* sim/sha256_hash_engine_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_hash_engine_tb
// streams messages into the sha-256 engine and compares every digest beat
// against a digest computed alongside in the testbench
// ----------------------------------------------------------------------------
module sha256_hash_engine_tb;
    import sha_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] data_word
    logic [2:0]  s_axis_tuser;   // [2:0] valid_bytes
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] digest_word
    logic        m_axis_tlast;

    sha256_hash_engine i_dut (.*);

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } t_digest_beat;

    localparam int LIMIT = 400000;

    t_digest_beat digest_q[$];
    logic [31:0]  hash_st [8];
    logic [31:0]  blk [16];
    logic [63:0]  msg_bits;
    int           fill_pos;
    int           n_err;
    int           cycles;
    int           hold_cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one compression of the buffered block into the hash state
    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        for (int i = 16; i < 64; i++)
            w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        for (int i = 0; i < 8; i++) v[i] = hash_st[i];
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KROUND[r] + w[r];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_st[i] += v[i];
    endtask

    task automatic buffer_word(logic [31:0] w);
        blk[fill_pos] = w;
        fill_pos++;
        if (fill_pos == 16) begin
            compress_block();
            fill_pos = 0;
        end
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++) hash_st[i] = HINIT[i];
        msg_bits = '0;
        fill_pos = 0;
    endtask

    // digest model: absorbs one input beat, queues digest beats on the last
    task automatic absorb_word(logic [31:0] data, logic [2:0] nb_in, logic eom);
        int nb;
        logic [31:0] mask;
        if (!eom) begin
            buffer_word(data);
            msg_bits += 32;
            return;
        end
        nb = (nb_in > 4) ? 4 : nb_in;
        msg_bits += nb * 8;
        if (nb == 4) begin
            buffer_word(data);
            buffer_word({PAD_BYTE, 24'h0});
        end else begin
            mask = (nb == 0) ? 32'h0 : (32'hFFFFFFFF << (32 - 8 * nb));
            buffer_word((data & mask) | (32'(PAD_BYTE) << (24 - 8 * nb)));
        end
        while (fill_pos != 14) buffer_word(32'h0);
        buffer_word(msg_bits[63:32]);
        buffer_word(msg_bits[31:0]);
        for (int i = 0; i < 8; i++) digest_q.push_back('{hash_st[i], i == 7});
        restart_hash();
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one beat and wait for its acceptance
    task automatic send_word(logic [31:0] data, logic [2:0] nb, logic eom);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= nb;
        s_axis_tlast  <= eom;
        do @(posedge i_clk); while (!s_axis_tready);
        absorb_word(data, nb, eom);
    endtask

    task automatic send_message(int words, logic [2:0] last_nb);
        for (int i = 0; i < words; i++)
            send_word($urandom, 3'($urandom), 1'b0);
        send_word($urandom, last_nb, 1'b1);
    endtask

    // receiver: random stalls, plus a long hold-off when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles   <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 9) < 7);
        end
    end

    // digest beat checker
    always @(posedge i_clk) begin
        t_digest_beat exp_beat;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (digest_q.size() == 0) begin
                $error("unexpected digest beat %h", m_axis_tdata);
                n_err++;
            end else begin
                exp_beat = digest_q.pop_front();
                if (m_axis_tdata !== exp_beat.word) begin
                    $error("digest_word expected %h actual %h", exp_beat.word, m_axis_tdata);
                    n_err++;
                end
                if (m_axis_tlast !== exp_beat.last) begin
                    $error("digest_last expected %b actual %b", exp_beat.last, m_axis_tlast);
                    n_err++;
                end
            end
        end
    end

    // directed: extremes and the special cases
    task automatic test_directed();
        send_word(32'h0, 3'd0, 1'b1);                  // empty message
        send_word(32'h61626300, 3'd3, 1'b1);           // "abc"
        send_word(32'hFFFFFFFF, 3'd4, 1'b1);
        send_word(32'hFFFFFFFF, 3'd7, 1'b1);           // count above four
        send_word(32'hA5A5A5A5, 3'd5, 1'b1);
        send_word(32'hFFFFFFFF, 3'd1, 1'b1);           // stray bits cleared
        send_word(32'hFFFFFFFF, 3'd2, 1'b1);
        send_word(32'h12345678, 3'd0, 1'b0);           // partial count not final
        send_word(32'hDEADBEEF, 3'd6, 1'b0);
        send_word(32'hFFFFFFFF, 3'd0, 1'b1);           // empty final word
        send_message(13, 3'd4);                        // length spills a block
        send_message(15, 3'd4);
    endtask

    // random messages of mostly short length
    task automatic test_random(int beats);
        int sent, n;
        sent = 0;
        while (sent < beats) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 18);
            send_message(n, 3'($urandom));
            sent += n + 1;
        end
    endtask

    // long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        hold_cycles = 2000;
        send_message(3, 3'd4);
        send_message(2, 3'd1);
        send_message(5, 3'd3);
    endtask

    task automatic drain();
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    initial begin
        cycles        = 0;
        n_err         = 0;
        hold_cycles   = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        restart_hash();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(180);
        s_axis_tvalid <= 1'b0;
        drain();
        if (n_err == 0 && digest_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
